[hdl/ssfi_pkg.sv]
package ssfi_pkg;

   localparam int FRAC_BITS_DEF = 12;

   localparam int SPEED_W     = 16;
   localparam int DRIVE_W     = 16;
   localparam int GAIN_W      = 31;
   localparam int OFFSET_W    = 12;
   localparam int ERR_W       = 32;
   localparam int ACC_W       = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int GAIN_FRAC_W = 16;
   localparam int DRIVE_LIMIT = 1500;

   localparam logic [GAIN_W-1:0] FWD_TARGET_GAIN_RST   = GAIN_W'(10527028);
   localparam logic [GAIN_W-1:0] FWD_INTEGRAL_GAIN_RST = GAIN_W'(240570);
   localparam logic [GAIN_W-1:0] FWD_SPEED_GAIN_RST    = GAIN_W'(3549810);
   localparam logic [GAIN_W-1:0] REV_TARGET_GAIN_RST   = GAIN_W'(6163392);
   localparam logic [GAIN_W-1:0] REV_INTEGRAL_GAIN_RST = GAIN_W'(76847);
   localparam logic [GAIN_W-1:0] REV_SPEED_GAIN_RST    = GAIN_W'(2067392);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FWD_TARGET_GAIN   = 3'd0,
      REG_FWD_INTEGRAL_GAIN = 3'd1,
      REG_FWD_SPEED_GAIN    = 3'd2,
      REG_REV_TARGET_GAIN   = 3'd3,
      REG_REV_INTEGRAL_GAIN = 3'd4,
      REG_REV_SPEED_GAIN    = 3'd5,
      REG_FWD_OFFSET        = 3'd6,
      REG_REV_OFFSET        = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]          fwd_target_gain;
      logic [GAIN_W-1:0]          fwd_integral_gain;
      logic [GAIN_W-1:0]          fwd_speed_gain;
      logic [GAIN_W-1:0]          rev_target_gain;
      logic [GAIN_W-1:0]          rev_integral_gain;
      logic [GAIN_W-1:0]          rev_speed_gain;
      logic signed [OFFSET_W-1:0] fwd_offset;
      logic signed [OFFSET_W-1:0] rev_offset;
   } csr_regs_type;

   typedef struct packed {
      logic stop;
      logic fwd;
   } stage_ctrl_type;

endpackage

[hdl/ssfi_csr.sv]
module ssfi_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ssfi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssfi_pkg::GAIN_W-1:0]         csr_wdata,
   output ssfi_pkg::csr_regs_type              csr_regs
);

   ssfi_pkg::csr_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_we) begin
         unique case (ssfi_pkg::csr_index_type'(csr_index))
            ssfi_pkg::REG_FWD_TARGET_GAIN:   regs_in.fwd_target_gain   = csr_wdata;
            ssfi_pkg::REG_FWD_INTEGRAL_GAIN: regs_in.fwd_integral_gain = csr_wdata;
            ssfi_pkg::REG_FWD_SPEED_GAIN:    regs_in.fwd_speed_gain    = csr_wdata;
            ssfi_pkg::REG_REV_TARGET_GAIN:   regs_in.rev_target_gain   = csr_wdata;
            ssfi_pkg::REG_REV_INTEGRAL_GAIN: regs_in.rev_integral_gain = csr_wdata;
            ssfi_pkg::REG_REV_SPEED_GAIN:    regs_in.rev_speed_gain    = csr_wdata;
            ssfi_pkg::REG_FWD_OFFSET:
               regs_in.fwd_offset = csr_wdata[ssfi_pkg::OFFSET_W-1:0];
            ssfi_pkg::REG_REV_OFFSET:
               regs_in.rev_offset = csr_wdata[ssfi_pkg::OFFSET_W-1:0];
            default: regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.fwd_target_gain   <= ssfi_pkg::FWD_TARGET_GAIN_RST;
         regs_ff.fwd_integral_gain <= ssfi_pkg::FWD_INTEGRAL_GAIN_RST;
         regs_ff.fwd_speed_gain    <= ssfi_pkg::FWD_SPEED_GAIN_RST;
         regs_ff.rev_target_gain   <= ssfi_pkg::REV_TARGET_GAIN_RST;
         regs_ff.rev_integral_gain <= ssfi_pkg::REV_INTEGRAL_GAIN_RST;
         regs_ff.rev_speed_gain    <= ssfi_pkg::REV_SPEED_GAIN_RST;
         regs_ff.fwd_offset        <= '0;
         regs_ff.rev_offset        <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_regs = regs_ff;

endmodule

[hdl/ssfi_integ.sv]
module ssfi_integ #(
   parameter int FRAC_BITS = ssfi_pkg::FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic signed [ssfi_pkg::SPEED_W-1:0]           req_target,
   input  logic signed [ssfi_pkg::SPEED_W-1:0]           req_measured,
   input  logic                                          stage_take,
   output logic                                          stage_valid,
   output ssfi_pkg::stage_ctrl_type                      stage_ctrl,
   output logic signed [((FRAC_BITS > ssfi_pkg::SPEED_W) ? FRAC_BITS
                         : ssfi_pkg::SPEED_W)-1:0]       stage_target,
   output logic signed [ssfi_pkg::SPEED_W-1:0]           stage_measured,
   output logic signed [ssfi_pkg::ERR_W-1:0]             stage_error_sum
);

   localparam int TgtW = (FRAC_BITS > ssfi_pkg::SPEED_W) ? FRAC_BITS : ssfi_pkg::SPEED_W;
   localparam int ErrW = ssfi_pkg::ERR_W;
   localparam logic signed [TgtW-1:0] MinFwd = TgtW'((2 * (2 ** FRAC_BITS) + 5) / 10);
   localparam logic signed [TgtW-1:0] MinRev = TgtW'(-((4 * (2 ** FRAC_BITS) + 5) / 10));
   localparam logic signed [ErrW-1:0] ErrMax = {1'b0, {(ErrW-1){1'b1}}};
   localparam logic signed [ErrW-1:0] ErrMin = {1'b1, {(ErrW-1){1'b0}}};

   logic                      req_accept;
   logic                      stop, fwd;
   logic signed [TgtW-1:0]    tgt_ext, tgt_clamped;
   logic signed [TgtW:0]      diff;
   logic signed [ErrW:0]      sum;
   logic signed [ErrW-1:0]    sum_sat;

   logic                      stage_valid_ff, stage_valid_in;
   ssfi_pkg::stage_ctrl_type  stage_ctrl_ff;
   logic signed [TgtW-1:0]    stage_target_ff;
   logic signed [ssfi_pkg::SPEED_W-1:0] stage_measured_ff;
   logic signed [ErrW-1:0]    error_sum_ff, error_sum_in;

   assign req_tready = !stage_valid_ff || stage_take;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      stop    = (req_target == '0);
      fwd     = !req_target[ssfi_pkg::SPEED_W-1] && !stop;
      tgt_ext = TgtW'(req_target);
      if (fwd) begin
         tgt_clamped = (tgt_ext < MinFwd) ? MinFwd : tgt_ext;
      end else begin
         tgt_clamped = (tgt_ext > MinRev) ? MinRev : tgt_ext;
      end
      diff = (TgtW+1)'(tgt_clamped) - (TgtW+1)'(req_measured);
      sum  = (ErrW+1)'(error_sum_ff) + (ErrW+1)'(diff);
      if (sum[ErrW] != sum[ErrW-1]) begin
         sum_sat = sum[ErrW] ? ErrMin : ErrMax;
      end else begin
         sum_sat = sum[ErrW-1:0];
      end
      error_sum_in = error_sum_ff;
      if (req_accept) begin
         error_sum_in = stop ? '0 : sum_sat;
      end
      stage_valid_in = req_accept ? 1'b1 : (stage_take ? 1'b0 : stage_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         error_sum_ff   <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         error_sum_ff   <= error_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_ctrl_ff.stop <= stop;
         stage_ctrl_ff.fwd  <= fwd;
         stage_target_ff    <= tgt_clamped;
         stage_measured_ff  <= req_measured;
      end
   end

   assign stage_valid     = stage_valid_ff;
   assign stage_ctrl      = stage_ctrl_ff;
   assign stage_target    = stage_target_ff;
   assign stage_measured  = stage_measured_ff;
   assign stage_error_sum = error_sum_ff;

`ifndef NO_ASSERTIONS
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && stop |=> error_sum_ff == '0)
      else $error("integrator not cleared by stop item");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_take |=> stage_valid_ff && $stable(stage_target_ff))
      else $error("stalled stage item changed");
`endif

endmodule

[hdl/ssfi_drive.sv]
module ssfi_drive #(
   parameter int FRAC_BITS = ssfi_pkg::FRAC_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          stage_valid,
   input  ssfi_pkg::stage_ctrl_type                      stage_ctrl,
   input  logic signed [((FRAC_BITS > ssfi_pkg::SPEED_W) ? FRAC_BITS
                         : ssfi_pkg::SPEED_W)-1:0]       stage_target,
   input  logic signed [ssfi_pkg::SPEED_W-1:0]           stage_measured,
   input  logic signed [ssfi_pkg::ERR_W-1:0]             stage_error_sum,
   input  ssfi_pkg::csr_regs_type                        csr_regs,
   output logic                                          stage_take,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic signed [ssfi_pkg::DRIVE_W-1:0]           rsp_drive
);

   localparam int TgtW      = (FRAC_BITS > ssfi_pkg::SPEED_W) ? FRAC_BITS : ssfi_pkg::SPEED_W;
   localparam int AccW      = ssfi_pkg::ACC_W;
   localparam int GainSW    = ssfi_pkg::GAIN_W + 1;
   localparam int FullShift = FRAC_BITS + ssfi_pkg::GAIN_FRAC_W;
   localparam logic signed [AccW-1:0] LimPos   = AccW'(ssfi_pkg::DRIVE_LIMIT);
   localparam logic signed [AccW-1:0] LimNeg   = AccW'(-ssfi_pkg::DRIVE_LIMIT);
   localparam logic signed [AccW-1:0] DriveMax = AccW'(2 ** (ssfi_pkg::DRIVE_W - 1) - 1);
   localparam logic signed [AccW-1:0] DriveMin = AccW'(-(2 ** (ssfi_pkg::DRIVE_W - 1)));

   logic signed [GainSW-1:0]                   gt_s, gi_s, gs_s;
   logic signed [ssfi_pkg::OFFSET_W-1:0]       off;
   logic signed [GainSW+TgtW-1:0]              prod_t;
   logic signed [GainSW+ssfi_pkg::ERR_W-1:0]   prod_i;
   logic signed [GainSW+ssfi_pkg::SPEED_W-1:0] prod_s;
   logic signed [AccW-1:0]                     acc, quot, quot_adj, clamped;
   logic                                       frac_nz;

   logic                                       rsp_valid_ff, rsp_valid_in;
   logic signed [ssfi_pkg::DRIVE_W-1:0]        drive_ff, drive_in;

   assign stage_take = stage_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (stage_ctrl.fwd) begin
         gt_s = $signed({1'b0, csr_regs.fwd_target_gain});
         gi_s = $signed({1'b0, csr_regs.fwd_integral_gain});
         gs_s = $signed({1'b0, csr_regs.fwd_speed_gain});
         off  = csr_regs.fwd_offset;
      end else begin
         gt_s = $signed({1'b0, csr_regs.rev_target_gain});
         gi_s = $signed({1'b0, csr_regs.rev_integral_gain});
         gs_s = $signed({1'b0, csr_regs.rev_speed_gain});
         off  = csr_regs.rev_offset;
      end
      prod_t = gt_s * stage_target;
      prod_i = gi_s * stage_error_sum;
      prod_s = gs_s * stage_measured;
      acc = AccW'(prod_t) + AccW'(prod_i) - AccW'(prod_s) + (AccW'(off) <<< FullShift);
      // divide with truncation toward zero
      quot    = acc >>> FullShift;
      frac_nz = |acc[FullShift-1:0];
      quot_adj = quot;
      if (acc[AccW-1] && frac_nz) begin
         quot_adj = quot + AccW'(1);
      end
      clamped = quot_adj;
      if (stage_ctrl.fwd) begin
         if (quot_adj > LimPos) begin
            clamped = LimPos;
         end else if (quot_adj < DriveMin) begin
            clamped = DriveMin;
         end
      end else begin
         if (quot_adj < LimNeg) begin
            clamped = LimNeg;
         end else if (quot_adj > DriveMax) begin
            clamped = DriveMax;
         end
      end
      drive_in     = stage_ctrl.stop ? '0 : clamped[ssfi_pkg::DRIVE_W-1:0];
      rsp_valid_in = stage_take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_take) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_drive  = drive_ff;

`ifndef NO_ASSERTIONS
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      stage_take && stage_ctrl.stop |=> drive_ff == '0)
      else $error("stop item gave nonzero drive");

   a_fwd_clamp: assert property (@(posedge clock) disable iff (reset)
      stage_take && stage_ctrl.fwd |=> drive_ff <= ssfi_pkg::DRIVE_LIMIT)
      else $error("forward drive above limit");
`endif

endmodule

[hdl/speed_state_feedback_integral_unit.sv]
// Speed controller with state feedback and integral action. Each request item
// carries a speed target and a measured speed (signed, FRAC_BITS fraction bits)
// and gives one signed integer drive item. A zero target clears the integrator
// and gives drive 0. The integrator is updated when an item is accepted; the
// gain products, offset and clamp are combinational between the stage register
// and the output register. One item is taken every cycle while rsp_tready is
// high, and each result passes both registers before the response port offers
// it. Gains and offsets must be written through the csr port only while no item
// is in flight; the block itself does not enforce this.
module speed_state_feedback_integral_unit #(
   parameter int FRAC_BITS = ssfi_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [31:0]                         req_tdata,  // target_speed, measured_speed
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // drive
   input  logic                                csr_we,
   input  logic [ssfi_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ssfi_pkg::GAIN_W-1:0]         csr_wdata
);

   localparam int TgtW = (FRAC_BITS > ssfi_pkg::SPEED_W) ? FRAC_BITS : ssfi_pkg::SPEED_W;
   localparam int SW   = ssfi_pkg::SPEED_W;

   ssfi_pkg::csr_regs_type              csr_regs;
   ssfi_pkg::stage_ctrl_type            stage_ctrl;
   logic                                stage_take, stage_valid;
   logic signed [TgtW-1:0]              stage_target;
   logic signed [SW-1:0]                stage_measured;
   logic signed [ssfi_pkg::ERR_W-1:0]   stage_error_sum;
   logic signed [ssfi_pkg::DRIVE_W-1:0] rsp_drive;

   ssfi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_regs  (csr_regs)
   );

   ssfi_integ #(.FRAC_BITS(FRAC_BITS)) u_integ (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_target      ($signed(req_tdata[SW-1:0])),
      .req_measured    ($signed(req_tdata[2*SW-1:SW])),
      .stage_take      (stage_take),
      .stage_valid     (stage_valid),
      .stage_ctrl      (stage_ctrl),
      .stage_target    (stage_target),
      .stage_measured  (stage_measured),
      .stage_error_sum (stage_error_sum)
   );

   ssfi_drive #(.FRAC_BITS(FRAC_BITS)) u_drive (
      .clock           (clock),
      .reset           (reset),
      .stage_valid     (stage_valid),
      .stage_ctrl      (stage_ctrl),
      .stage_target    (stage_target),
      .stage_measured  (stage_measured),
      .stage_error_sum (stage_error_sum),
      .csr_regs        (csr_regs),
      .stage_take      (stage_take),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_drive       (rsp_drive)
   );

   assign rsp_tdata = rsp_drive;

endmodule

[test/drive_checker.sv]
module drive_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [31:0]                      req_tdata,  // target_speed, measured_speed
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [15:0]                      rsp_tdata,  // drive
   input  logic                             csr_we,
   input  logic [ssfi_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssfi_pkg::GAIN_W-1:0]      csr_wdata,
   output int                               fail_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_SHIFT = ssfi_pkg::FRAC_BITS_DEF + ssfi_pkg::GAIN_FRAC_W;
   localparam longint MIN_FWD_TARGET =
      (2 * (longint'(1) << ssfi_pkg::FRAC_BITS_DEF) + 5) / 10;
   localparam longint MIN_REV_TARGET =
      -((4 * (longint'(1) << ssfi_pkg::FRAC_BITS_DEF) + 5) / 10);
   localparam longint ERR_MAX = (longint'(1) << (ssfi_pkg::ERR_W - 1)) - 1;
   localparam longint ERR_MIN = -(longint'(1) << (ssfi_pkg::ERR_W - 1));
   localparam longint DRIVE_MAX = (longint'(1) << (ssfi_pkg::DRIVE_W - 1)) - 1;
   localparam longint DRIVE_MIN = -(longint'(1) << (ssfi_pkg::DRIVE_W - 1));

   ssfi_pkg::csr_regs_type            coeffs;
   logic signed [ssfi_pkg::ERR_W-1:0] error_sum;
   logic [ssfi_pkg::DRIVE_W-1:0]      expected_drive_q[$];
   int                                mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 200) begin
         $display("%0t ns drive check: %s", $time, msg);
      end
   endtask

   // updates the integrator copy and gives the drive for one item
   function automatic logic [ssfi_pkg::DRIVE_W-1:0] predict_drive(
      input logic signed [ssfi_pkg::SPEED_W-1:0] target_raw,
      input logic signed [ssfi_pkg::SPEED_W-1:0] measured_raw
   );
      longint tgt, spd, sum, acc, q, gt, gi, gs, off;
      bit     fwd;
      tgt = target_raw;
      spd = measured_raw;
      if (tgt == 0) begin
         error_sum = '0;
         return '0;
      end
      fwd = (tgt > 0);
      if (fwd) begin
         if (tgt < MIN_FWD_TARGET) tgt = MIN_FWD_TARGET;
         gt  = coeffs.fwd_target_gain;
         gi  = coeffs.fwd_integral_gain;
         gs  = coeffs.fwd_speed_gain;
         off = $signed(coeffs.fwd_offset);
      end else begin
         if (tgt > MIN_REV_TARGET) tgt = MIN_REV_TARGET;
         gt  = coeffs.rev_target_gain;
         gi  = coeffs.rev_integral_gain;
         gs  = coeffs.rev_speed_gain;
         off = $signed(coeffs.rev_offset);
      end
      sum = longint'(error_sum) + (tgt - spd);
      if (sum > ERR_MAX) sum = ERR_MAX;
      if (sum < ERR_MIN) sum = ERR_MIN;
      error_sum = ssfi_pkg::ERR_W'(sum);
      acc = gt * tgt + gi * longint'(error_sum) - gs * spd + off * (longint'(1) << FULL_SHIFT);
      q = acc / (longint'(1) << FULL_SHIFT);
      if (fwd) begin
         if (q > ssfi_pkg::DRIVE_LIMIT) q = ssfi_pkg::DRIVE_LIMIT;
         if (q < DRIVE_MIN) q = DRIVE_MIN;
      end else begin
         if (q < -ssfi_pkg::DRIVE_LIMIT) q = -ssfi_pkg::DRIVE_LIMIT;
         if (q > DRIVE_MAX) q = DRIVE_MAX;
      end
      return ssfi_pkg::DRIVE_W'(q);
   endfunction

   always @(posedge clock) begin
      logic [ssfi_pkg::DRIVE_W-1:0] want;
      if (reset) begin
         coeffs.fwd_target_gain   = ssfi_pkg::FWD_TARGET_GAIN_RST;
         coeffs.fwd_integral_gain = ssfi_pkg::FWD_INTEGRAL_GAIN_RST;
         coeffs.fwd_speed_gain    = ssfi_pkg::FWD_SPEED_GAIN_RST;
         coeffs.rev_target_gain   = ssfi_pkg::REV_TARGET_GAIN_RST;
         coeffs.rev_integral_gain = ssfi_pkg::REV_INTEGRAL_GAIN_RST;
         coeffs.rev_speed_gain    = ssfi_pkg::REV_SPEED_GAIN_RST;
         coeffs.fwd_offset        = '0;
         coeffs.rev_offset        = '0;
         error_sum                = '0;
         expected_drive_q.delete();
      end else begin
         if ($isunknown(rsp_tvalid)) begin
            report_mismatch("rsp_tvalid unknown");
         end else if (rsp_tvalid && rsp_tready) begin
            if (expected_drive_q.size() == 0) begin
               report_mismatch($sformatf("unexpected drive %0d", $signed(rsp_tdata)));
            end else begin
               want = expected_drive_q.pop_front();
               if (rsp_tdata !== want) begin
                  report_mismatch($sformatf("drive %0d, expected %0d",
                                            $signed(rsp_tdata), $signed(want)));
               end
            end
         end
         if (csr_we) begin
            case (ssfi_pkg::csr_index_type'(csr_index))
               ssfi_pkg::REG_FWD_TARGET_GAIN:   coeffs.fwd_target_gain   = csr_wdata;
               ssfi_pkg::REG_FWD_INTEGRAL_GAIN: coeffs.fwd_integral_gain = csr_wdata;
               ssfi_pkg::REG_FWD_SPEED_GAIN:    coeffs.fwd_speed_gain    = csr_wdata;
               ssfi_pkg::REG_REV_TARGET_GAIN:   coeffs.rev_target_gain   = csr_wdata;
               ssfi_pkg::REG_REV_INTEGRAL_GAIN: coeffs.rev_integral_gain = csr_wdata;
               ssfi_pkg::REG_REV_SPEED_GAIN:    coeffs.rev_speed_gain    = csr_wdata;
               ssfi_pkg::REG_FWD_OFFSET:
                  coeffs.fwd_offset = csr_wdata[ssfi_pkg::OFFSET_W-1:0];
               ssfi_pkg::REG_REV_OFFSET:
                  coeffs.rev_offset = csr_wdata[ssfi_pkg::OFFSET_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_drive_q.push_back(predict_drive(req_tdata[15:0], req_tdata[31:16]));
         end
      end
      pending_count <= expected_drive_q.size();
      fail_count    <= mismatches;
   end

endmodule

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [31:0]                      req_tdata;  // target_speed, measured_speed
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [15:0]                      rsp_tdata;  // drive
   logic                             csr_we;
   logic [ssfi_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ssfi_pkg::GAIN_W-1:0]      csr_wdata;
   int                               fail_count;
   int                               pending_count;
   bit                               steady;

   speed_state_feedback_integral_unit u_dut (.*);

   drive_checker u_drive_checker (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= 26);
   end

   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 26);
   endfunction

   task automatic send_speed(input int target, input int measured);
      @(negedge clock);
      while (take_break()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {16'(measured), 16'(target)};
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input ssfi_pkg::csr_index_type idx,
                            input logic [ssfi_pkg::GAIN_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic load_coeffs(
      input logic [ssfi_pkg::GAIN_W-1:0]   ft, fi, fs, rt, ri, rs,
      input logic [ssfi_pkg::OFFSET_W-1:0] fo, ro
   );
      write_csr(ssfi_pkg::REG_FWD_TARGET_GAIN, ft);
      write_csr(ssfi_pkg::REG_FWD_INTEGRAL_GAIN, fi);
      write_csr(ssfi_pkg::REG_FWD_SPEED_GAIN, fs);
      write_csr(ssfi_pkg::REG_REV_TARGET_GAIN, rt);
      write_csr(ssfi_pkg::REG_REV_INTEGRAL_GAIN, ri);
      write_csr(ssfi_pkg::REG_REV_SPEED_GAIN, rs);
      // upper bits are don't-care for the offsets
      write_csr(ssfi_pkg::REG_FWD_OFFSET,
                {(ssfi_pkg::GAIN_W - ssfi_pkg::OFFSET_W)'($urandom()), fo});
      write_csr(ssfi_pkg::REG_REV_OFFSET,
                {(ssfi_pkg::GAIN_W - ssfi_pkg::OFFSET_W)'($urandom()), ro});
   endtask

   function automatic logic [ssfi_pkg::GAIN_W-1:0] random_gain();
      case ($urandom_range(3))
         0:       return ssfi_pkg::GAIN_W'($urandom());
         1:       return $urandom_range(1) ? {ssfi_pkg::GAIN_W{1'b1}}
                                           : {ssfi_pkg::GAIN_W{1'b0}};
         default: return ssfi_pkg::GAIN_W'($urandom_range(1 << 24));
      endcase
   endfunction

   function automatic logic [ssfi_pkg::OFFSET_W-1:0] random_offset();
      if ($urandom_range(1)) return ssfi_pkg::OFFSET_W'($urandom());
      return ssfi_pkg::OFFSET_W'(int'($urandom_range(2 * ssfi_pkg::DRIVE_LIMIT))
                                 - ssfi_pkg::DRIVE_LIMIT);
   endfunction

   function automatic int random_target();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return 0;
      // around the minimum magnitudes
      if (pick < 25) return int'($urandom_range(3400)) - 1700;
      if (pick < 33) begin
         case ($urandom_range(3))
            0:       return 32767;
            1:       return -32768;
            2:       return 1;
            default: return -1;
         endcase
      end
      return int'($signed(16'($urandom())));
   endfunction

   function automatic int random_measured(input int target);
      if ($urandom_range(99) < 30) return target + int'($urandom_range(400)) - 200;
      return int'($signed(16'($urandom())));
   endfunction

   initial begin
      int target;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      steady     = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_speed(0, 12345);
      send_speed(1, 0);
      send_speed(818, 0);
      send_speed(819, 100);
      send_speed(820, -100);
      send_speed(-1, 0);
      send_speed(-1637, 0);
      send_speed(-1638, 0);
      send_speed(-1639, 0);
      send_speed(32767, -32768);
      send_speed(-32768, 32767);
      send_speed(32767, 32767);
      send_speed(-32768, -32768);
      send_speed(0, -32768);
      send_speed(4096, 4000);
      send_speed(-4096, -4000);

      drain();
      load_coeffs('1, '1, '1, '1, '1, '1, 12'h7FF, 12'h800);
      send_speed(1, 32767);
      send_speed(-1, -32768);
      send_speed(0, 0);
      send_speed(32767, 0);

      drain();
      load_coeffs('0, '0, '0, '0, '0, '0, ssfi_pkg::OFFSET_W'(ssfi_pkg::DRIVE_LIMIT),
                  ssfi_pkg::OFFSET_W'(-ssfi_pkg::DRIVE_LIMIT));
      send_speed(100, 0);
      send_speed(-100, 0);
      drain();
      load_coeffs('0, '0, '0, '0, '0, '0, ssfi_pkg::OFFSET_W'(-ssfi_pkg::DRIVE_LIMIT),
                  ssfi_pkg::OFFSET_W'(ssfi_pkg::DRIVE_LIMIT));
      send_speed(5, 5);
      send_speed(-5, -5);

      // long run in each direction, small gain keeps the integrator visible
      drain();
      load_coeffs('0, ssfi_pkg::GAIN_W'(1), '0, '0, ssfi_pkg::GAIN_W'(1), '0, '0, '0);
      steady = 1'b1;
      for (int n = 0; n < 100; n++) begin
         send_speed(32767 - int'($urandom_range(2767)), -32768 + int'($urandom_range(2768)));
      end
      send_speed(0, int'($urandom_range(65535)));
      for (int n = 0; n < 100; n++) begin
         send_speed(-32768 + int'($urandom_range(2768)), 32767 - int'($urandom_range(2767)));
      end
      steady = 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         if (phase == 0) begin
            load_coeffs(ssfi_pkg::FWD_TARGET_GAIN_RST, ssfi_pkg::FWD_INTEGRAL_GAIN_RST,
                        ssfi_pkg::FWD_SPEED_GAIN_RST, ssfi_pkg::REV_TARGET_GAIN_RST,
                        ssfi_pkg::REV_INTEGRAL_GAIN_RST, ssfi_pkg::REV_SPEED_GAIN_RST,
                        random_offset(), random_offset());
         end else begin
            load_coeffs(random_gain(), random_gain(), random_gain(),
                        random_gain(), random_gain(), random_gain(),
                        random_offset(), random_offset());
         end
         for (int n = 0; n < 210; n++) begin
            steady = (phase == 2) && (n >= 40) && (n < 200);
            target = random_target();
            send_speed(target, random_measured(target));
         end
      end
      steady = 1'b0;
      drain();
      repeat (10) @(negedge clock);

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
